// ===== rtl/thermal_charge_current_policy_unit_macros.svh =====
// Assertion helpers for the thermal charge current policy unit.
// Each helper checks on the rising edge of clk and is off while rstn is low.
`ifndef THERMAL_CHARGE_CURRENT_POLICY_UNIT_MACROS_SVH
`define THERMAL_CHARGE_CURRENT_POLICY_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cons must hold whenever ante holds.
`define TCCP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define TCCP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCCP_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define TCCP_ASSERT_NXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/tccp_pkg.sv =====
`default_nettype none

package tccp_pkg;

    // Field widths
    localparam int TempW     = 8;
    localparam int CurrentW  = 13;
    localparam int IntervalW = 8;
    localparam int DeltaW    = 4;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 13;

    // Register reset values
    localparam logic [IntervalW-1:0] SampleIntervalRst  = 8'd5;
    localparam logic [DeltaW-1:0]    HysteresisDeltaRst = 4'd3;
    localparam logic [TempW-1:0]     BoundColdRst       = 8'hE2;  // -30 C
    localparam logic [TempW-1:0]     BoundCoolRst       = 8'd0;
    localparam logic [TempW-1:0]     BoundWarmRst       = 8'd45;
    localparam logic [TempW-1:0]     BoundHotRst        = 8'd60;
    localparam logic [CurrentW-1:0]  ReducedCurrentRst  = 13'd400;
    localparam logic [CurrentW-1:0]  FullCurrentRst     = 13'd1500;

    // Chip temperature wins when the sensors disagree by more than this
    localparam logic [TempW:0] TempDisagree = 9'd10;

    // Tick divider saturation value
    localparam logic [IntervalW-1:0] TickMax = {IntervalW{1'b1}};

    // Register indexes on the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SAMPLE_INTERVAL  = 3'd0,
        CFG_HYSTERESIS_DELTA = 3'd1,
        CFG_BOUND_COLD       = 3'd2,
        CFG_BOUND_COOL       = 3'd3,
        CFG_BOUND_WARM       = 3'd4,
        CFG_BOUND_HOT        = 3'd5,
        CFG_REDUCED_CURRENT  = 3'd6,
        CFG_FULL_CURRENT     = 3'd7
    } tccp_cfg_idx_t;

    // Live configuration; bounds are two's complement degrees C
    typedef struct packed {
        logic [IntervalW-1:0] sample_interval;
        logic [DeltaW-1:0]    hysteresis_delta;
        logic [TempW-1:0]     bound_cold;
        logic [TempW-1:0]     bound_cool;
        logic [TempW-1:0]     bound_warm;
        logic [TempW-1:0]     bound_hot;
        logic [CurrentW-1:0]  reduced_current_ma;
        logic [CurrentW-1:0]  full_current_ma;
    } tccp_cfg_t;

    // Outcome of one temperature decision
    typedef struct packed {
        logic                write_current;
        logic [CurrentW-1:0] target_current_ma;
        logic                write_enable;
        logic                enable_value;
    } tccp_decision_t;

endpackage

`default_nettype wire

// ===== rtl/tccp_cfg_regs.sv =====
`default_nettype none

module tccp_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tccp_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [tccp_pkg::CfgDataW-1:0] cfg_wdata,
    output tccp_pkg::tccp_cfg_t                cfg
);
    import tccp_pkg::*;

    tccp_cfg_t cfg_reg;
    tccp_cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (tccp_cfg_idx_t'(cfg_index))
                CFG_SAMPLE_INTERVAL:  cfg_next.sample_interval    = cfg_wdata[IntervalW-1:0];
                CFG_HYSTERESIS_DELTA: cfg_next.hysteresis_delta   = cfg_wdata[DeltaW-1:0];
                CFG_BOUND_COLD:       cfg_next.bound_cold         = cfg_wdata[TempW-1:0];
                CFG_BOUND_COOL:       cfg_next.bound_cool         = cfg_wdata[TempW-1:0];
                CFG_BOUND_WARM:       cfg_next.bound_warm         = cfg_wdata[TempW-1:0];
                CFG_BOUND_HOT:        cfg_next.bound_hot          = cfg_wdata[TempW-1:0];
                CFG_REDUCED_CURRENT:  cfg_next.reduced_current_ma = cfg_wdata[CurrentW-1:0];
                CFG_FULL_CURRENT:     cfg_next.full_current_ma    = cfg_wdata[CurrentW-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold registers, load defaults at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_interval    <= SampleIntervalRst;
            cfg_reg.hysteresis_delta   <= HysteresisDeltaRst;
            cfg_reg.bound_cold         <= BoundColdRst;
            cfg_reg.bound_cool         <= BoundCoolRst;
            cfg_reg.bound_warm         <= BoundWarmRst;
            cfg_reg.bound_hot          <= BoundHotRst;
            cfg_reg.reduced_current_ma <= ReducedCurrentRst;
            cfg_reg.full_current_ma    <= FullCurrentRst;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/tccp_decide.sv =====
`default_nettype none

module tccp_decide (
    input  tccp_pkg::tccp_cfg_t                      cfg,
    input  wire logic signed [tccp_pkg::TempW-1:0]   battery_temp_c,
    input  wire logic signed [tccp_pkg::TempW-1:0]   chip_temp_c,
    input  wire logic        [tccp_pkg::CurrentW-1:0] current_setting_ma,
    input  wire logic                                charge_enabled,
    input  wire logic                                first_sample,
    output tccp_pkg::tccp_decision_t                 decision
);
    import tccp_pkg::*;

    logic signed [TempW-1:0] b_cold;
    logic signed [TempW-1:0] b_cool;
    logic signed [TempW-1:0] b_warm;
    logic signed [TempW-1:0] b_hot;
    logic signed [TempW-1:0] temp;
    logic [TempW:0]          sensor_gap;
    logic [CurrentW-1:0]     zone_i;
    logic [CurrentW-1:0]     left_i;
    logic [CurrentW-1:0]     right_i;
    logic signed [TempW-1:0] left_b;
    logic signed [TempW-1:0] right_b;
    logic                    has_left;
    logic                    has_right;
    logic                    keep_left;
    logic                    keep_right;
    logic [CurrentW-1:0]     target;

    // Magnitude of a difference of two signed temperatures
    function automatic logic [TempW:0] abs_diff(input logic signed [TempW-1:0] a,
                                                input logic signed [TempW-1:0] b);
        logic signed [TempW:0] d;
        begin
            d = {a[TempW-1], a} - {b[TempW-1], b};
            abs_diff = d[TempW] ? (~d + {{TempW{1'b0}}, 1'b1}) : d;
        end
    endfunction

    assign b_cold = cfg.bound_cold;
    assign b_cool = cfg.bound_cool;
    assign b_warm = cfg.bound_warm;
    assign b_hot  = cfg.bound_hot;

    // Pick the chip sensor when the two readings disagree
    assign sensor_gap = abs_diff(chip_temp_c, battery_temp_c);
    assign temp       = (sensor_gap > TempDisagree) ? chip_temp_c : battery_temp_c;

    // Map temperature to a zone and its neighbors, first matching test wins
    always_comb begin
        has_left  = 1'b1;
        has_right = 1'b1;
        left_i    = '0;
        right_i   = '0;
        left_b    = b_cold;
        right_b   = b_cold;
        if (temp <= b_cold) begin
            zone_i    = '0;
            has_left  = 1'b0;
            right_i   = cfg.reduced_current_ma;
            right_b   = b_cold;
        end else if (temp <= b_cool) begin
            zone_i    = cfg.reduced_current_ma;
            left_i    = '0;
            left_b    = b_cold;
            right_i   = cfg.full_current_ma;
            right_b   = b_cool;
        end else if (temp < b_warm) begin
            zone_i    = cfg.full_current_ma;
            left_i    = cfg.reduced_current_ma;
            left_b    = b_cool;
            right_i   = cfg.reduced_current_ma;
            right_b   = b_warm;
        end else if (temp < b_hot) begin
            zone_i    = cfg.reduced_current_ma;
            left_i    = cfg.full_current_ma;
            left_b    = b_warm;
            right_i   = '0;
            right_b   = b_hot;
        end else begin
            zone_i    = '0;
            left_i    = cfg.reduced_current_ma;
            left_b    = b_hot;
            has_right = 1'b0;
        end
    end

    // Keep a neighbor's current near the shared bound; hotter side wins
    assign keep_left  = has_left && (current_setting_ma == left_i) &&
                        (abs_diff(temp, left_b) <= {{(TempW+1-DeltaW){1'b0}},
                                                    cfg.hysteresis_delta});
    assign keep_right = has_right && (current_setting_ma == right_i) &&
                        (abs_diff(temp, right_b) <= {{(TempW+1-DeltaW){1'b0}},
                                                     cfg.hysteresis_delta});

    always_comb begin
        target = zone_i;
        if (!first_sample) begin
            if (keep_left) begin
                target = left_i;
            end
            if (keep_right) begin
                target = right_i;
            end
        end
    end

    // Request current and enable writes
    always_comb begin
        decision.target_current_ma = target;
        decision.write_current     = (current_setting_ma != target);
        decision.write_enable      = 1'b0;
        decision.enable_value      = 1'b0;
        if ((target == '0) && charge_enabled) begin
            decision.write_enable = 1'b1;
        end else if ((target != '0) && !charge_enabled) begin
            decision.write_enable = 1'b1;
            decision.enable_value = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/thermal_charge_current_policy_unit.sv =====
// Thermal charge current policy unit.
//
// Input channel (s_*): one request per charger tick with power presence, an
// init flag, battery and chip temperatures and the charger's current and
// enable readback. Output channel (m_*): exactly one result per request,
// telling whether a temperature decision was taken and which current and
// enable writes the charger needs. Both channels use valid/ready.
// Configuration (cfg_*): eight registers written by index, one per cycle, by
// the user only while no request is in flight; the block does not enforce it.
//
// Pipeline: a request accepted into the input register passes through the zone
// and hysteresis compare logic into the result register, which drives m_*.
// Throughput is one request per cycle while the receiver does not stall; the
// compare path between the two registers sets the rate.
//
// Reset loads the register defaults, clears the tick divider and arms the
// first-sample flag. When the receiver stalls, the result register holds and
// the input register still takes one more request; after that s_ready drops
// until the result is taken.

`default_nettype none

module thermal_charge_current_policy_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic        [tccp_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic        [tccp_pkg::CfgDataW-1:0] cfg_wdata,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_power_ok,
    input  wire logic                                 s_reinit,
    input  wire logic signed [tccp_pkg::TempW-1:0]    s_battery_temp_c,
    input  wire logic signed [tccp_pkg::TempW-1:0]    s_chip_temp_c,
    input  wire logic        [tccp_pkg::CurrentW-1:0] s_current_setting_ma,
    input  wire logic                                 s_charge_enabled,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_sampled,
    output logic                                      m_write_current,
    output logic             [tccp_pkg::CurrentW-1:0] m_target_current_ma,
    output logic                                      m_write_enable,
    output logic                                      m_enable_value
);
    import tccp_pkg::*;

`include "thermal_charge_current_policy_unit_macros.svh"

    tccp_cfg_t      cfg;
    tccp_decision_t decision;

    // Input register
    logic                       in_valid_reg;
    logic                       power_ok_reg;
    logic                       reinit_reg;
    logic signed [TempW-1:0]    battery_temp_reg;
    logic signed [TempW-1:0]    chip_temp_reg;
    logic        [CurrentW-1:0] setting_reg;
    logic                       enabled_reg;

    // Policy state
    logic [IntervalW-1:0] tick_count_reg;
    logic [IntervalW-1:0] tick_count_next;
    logic                 first_sample_reg;
    logic                 first_sample_next;

    // Result register
    logic                out_valid_reg;
    logic                sampled_reg;
    tccp_decision_t      result_reg;
    logic                sampled_next;
    tccp_decision_t      result_next;

    logic                 advance;
    logic                 take;
    logic [IntervalW-1:0] tick_inc;
    logic                 first_eff;

    tccp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tccp_decide u_decide (
        .cfg                (cfg),
        .battery_temp_c     (battery_temp_reg),
        .chip_temp_c        (chip_temp_reg),
        .current_setting_ma (setting_reg),
        .charge_enabled     (enabled_reg),
        .first_sample       (first_eff),
        .decision           (decision)
    );

    // Move the stage when the result register is free or being drained
    assign advance = !out_valid_reg || m_ready;
    assign take    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Tick divider and first-sample flag
    assign tick_inc = (tick_count_reg < TickMax) ? (tick_count_reg + IntervalW'(1))
                                                 : tick_count_reg;

    always_comb begin
        tick_count_next   = tick_count_reg;
        first_sample_next = first_sample_reg;
        sampled_next      = 1'b0;
        first_eff         = first_sample_reg;
        if (!power_ok_reg) begin
            tick_count_next   = '0;
            first_sample_next = 1'b1;
        end else if (reinit_reg) begin
            tick_count_next   = '0;
            first_eff         = 1'b1;
            first_sample_next = 1'b0;
            sampled_next      = 1'b1;
        end else if (tick_inc < cfg.sample_interval) begin
            tick_count_next   = tick_inc;
        end else begin
            tick_count_next   = '0;
            first_sample_next = 1'b0;
            sampled_next      = 1'b1;
        end
    end

    // Zero every field when no decision is taken
    always_comb begin
        result_next = '0;
        if (sampled_next) begin
            result_next = decision;
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            tick_count_reg   <= '0;
            first_sample_reg <= 1'b1;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (take) begin
                tick_count_reg   <= tick_count_next;
                first_sample_reg <= first_sample_next;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            power_ok_reg     <= s_power_ok;
            reinit_reg       <= s_reinit;
            battery_temp_reg <= s_battery_temp_c;
            chip_temp_reg    <= s_chip_temp_c;
            setting_reg      <= s_current_setting_ma;
            enabled_reg      <= s_charge_enabled;
        end
        if (take) begin
            sampled_reg <= sampled_next;
            result_reg  <= result_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_sampled           = sampled_reg;
    assign m_write_current     = result_reg.write_current;
    assign m_target_current_ma = result_reg.target_current_ma;
    assign m_write_enable      = result_reg.write_enable;
    assign m_enable_value      = result_reg.enable_value;

    `TCCP_ASSERT_IMP(a_idle_result_clear, aclk, aresetn,
        out_valid_reg && !sampled_reg,
        !result_reg.write_current && !result_reg.write_enable && (result_reg.target_current_ma == '0),
        "result without a decision carries a request")

    `TCCP_ASSERT_IMP(a_enable_value_gated, aclk, aresetn,
        out_valid_reg && !result_reg.write_enable,
        !result_reg.enable_value,
        "enable value set without an enable write")

    `TCCP_ASSERT_IMP(a_stall_only_when_full, aclk, aresetn,
        !s_ready,
        in_valid_reg && out_valid_reg && !m_ready,
        "input stalled while the pipeline can move")

    `TCCP_ASSERT_NXT(a_no_power_rearms, aclk, aresetn,
        take && !power_ok_reg,
        first_sample_reg && (tick_count_reg == '0),
        "missing power did not re-arm the first sample")

    `TCCP_ASSERT_NXT(a_decision_clears_first, aclk, aresetn,
        take && sampled_next,
        !first_sample_reg && (tick_count_reg == '0) && out_valid_reg && sampled_reg,
        "decision did not clear the first sample flag")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
    import tccp_pkg::*;

    typedef struct packed {
        logic                       power_ok;
        logic                       reinit;
        logic signed [TempW-1:0]    battery_temp_c;
        logic signed [TempW-1:0]    chip_temp_c;
        logic        [CurrentW-1:0] current_setting_ma;
        logic                       charge_enabled;
    } tick_req_t;

    typedef struct packed {
        logic                sampled;
        logic                write_current;
        logic [CurrentW-1:0] target_current_ma;
        logic                write_enable;
        logic                enable_value;
    } charge_decision_t;

    typedef struct packed {
        tick_req_t        req;
        logic             known;
        charge_decision_t result;
    } directed_row_t;

    localparam charge_decision_t NO_DECISION = '0;
    localparam int NUM_PHASES      = 14;
    localparam int TICKS_PER_PHASE = 125;
    localparam int LONG_HOLD       = 300;

    // Hand-written ticks under the reset configuration
    directed_row_t directed_rows [0:21] = '{
        // no power, init ignored
        '{'{1'b0, 1'b1, 8'sd127, -8'sd128, 13'd8191, 1'b1}, 1'b1, NO_DECISION},
        // init forces the first decision: full current, enable
        '{'{1'b1, 1'b1, 8'sd25, 8'sd25, 13'd0, 1'b0}, 1'b1,
          '{1'b1, 1'b1, 13'd1500, 1'b1, 1'b1}},
        '{'{1'b1, 1'b0, 8'sd25, 8'sd25, 13'd1500, 1'b1}, 1'b1, NO_DECISION},
        '{'{1'b1, 1'b0, 8'sd25, 8'sd25, 13'd1500, 1'b1}, 1'b1, NO_DECISION},
        '{'{1'b1, 1'b0, 8'sd25, 8'sd25, 13'd1500, 1'b1}, 1'b1, NO_DECISION},
        '{'{1'b1, 1'b0, 8'sd25, 8'sd25, 13'd1500, 1'b1}, 1'b1, NO_DECISION},
        // fifth tick samples; setting already matches, nothing to write
        '{'{1'b1, 1'b0, 8'sd44, 8'sd44, 13'd1500, 1'b1}, 1'b1,
          '{1'b1, 1'b0, 13'd1500, 1'b0, 1'b0}},
        '{'{1'b1, 1'b0, 8'sd46, 8'sd46, 13'd1500, 1'b0}, 1'b1, NO_DECISION},
        '{'{1'b1, 1'b0, 8'sd46, 8'sd46, 13'd1500, 1'b0}, 1'b1, NO_DECISION},
        '{'{1'b1, 1'b0, 8'sd46, 8'sd46, 13'd1500, 1'b0}, 1'b1, NO_DECISION},
        '{'{1'b1, 1'b0, 8'sd46, 8'sd46, 13'd1500, 1'b0}, 1'b1, NO_DECISION},
        // warm zone just past the bound: hysteresis keeps full current
        '{'{1'b1, 1'b0, 8'sd46, 8'sd46, 13'd1500, 1'b0}, 1'b0, NO_DECISION},
        // sensors disagree: chip temperature puts us in the hot zone
        '{'{1'b1, 1'b1, 8'sd0, 8'sd127, 13'd8191, 1'b1}, 1'b1,
          '{1'b1, 1'b1, 13'd0, 1'b1, 1'b0}},
        // difference of exactly ten keeps the battery temperature
        '{'{1'b1, 1'b1, -8'sd128, -8'sd118, 13'd0, 1'b0}, 1'b1,
          '{1'b1, 1'b0, 13'd0, 1'b0, 1'b0}},
        '{'{1'b1, 1'b1, 8'sd127, 8'sd127, 13'd0, 1'b1}, 1'b0, NO_DECISION},
        '{'{1'b0, 1'b1, -8'sd1, -8'sd1, 13'd6000, 1'b0}, 1'b1, NO_DECISION},
        '{'{1'b1, 1'b1, -8'sd30, -8'sd30, 13'd400, 1'b1}, 1'b0, NO_DECISION},
        '{'{1'b1, 1'b0, -8'sd28, -8'sd28, 13'd400, 1'b1}, 1'b1, NO_DECISION},
        '{'{1'b1, 1'b0, -8'sd28, -8'sd28, 13'd400, 1'b1}, 1'b1, NO_DECISION},
        '{'{1'b1, 1'b0, -8'sd28, -8'sd28, 13'd400, 1'b1}, 1'b1, NO_DECISION},
        '{'{1'b1, 1'b0, -8'sd28, -8'sd28, 13'd400, 1'b1}, 1'b1, NO_DECISION},
        '{'{1'b1, 1'b0, -8'sd28, -8'sd28, 13'd400, 1'b0}, 1'b0, NO_DECISION}
    };

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    tccp_cfg_idx_t              cfg_index = CFG_SAMPLE_INTERVAL;
    logic        [CfgDataW-1:0] cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_power_ok = 1'b0;
    logic                       s_reinit = 1'b0;
    logic signed [TempW-1:0]    s_battery_temp_c = '0;
    logic signed [TempW-1:0]    s_chip_temp_c = '0;
    logic        [CurrentW-1:0] s_current_setting_ma = '0;
    logic                       s_charge_enabled = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_sampled;
    logic                       m_write_current;
    logic        [CurrentW-1:0] m_target_current_ma;
    logic                       m_write_enable;
    logic                       m_enable_value;

    // Policy shadow: configuration and divider state
    tccp_cfg_t   cfg_shadow;
    int unsigned tick_cnt;
    bit          first_pending;

    charge_decision_t pending_decisions [$];
    charge_decision_t want, got;
    int  error_count = 0;
    bit  req_taken = 1'b0;
    bit  known_valid = 1'b0;
    charge_decision_t known_result = '0;
    bit  quiet = 1'b0;
    bit  hold_off_request = 1'b0;
    int  rx_hold = 0;

    thermal_charge_current_policy_unit i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_power_ok           (s_power_ok),
        .s_reinit             (s_reinit),
        .s_battery_temp_c     (s_battery_temp_c),
        .s_chip_temp_c        (s_chip_temp_c),
        .s_current_setting_ma (s_current_setting_ma),
        .s_charge_enabled     (s_charge_enabled),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_sampled            (m_sampled),
        .m_write_current      (m_write_current),
        .m_target_current_ma  (m_target_current_ma),
        .m_write_enable       (m_write_enable),
        .m_enable_value       (m_enable_value)
    );

    always #5 aclk = ~aclk;

    function automatic int degree_gap(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Compute the decision for one tick and advance the divider state
    function automatic charge_decision_t policy_decision(tick_req_t r);
        charge_decision_t d;
        int t, tbat, tchip, dlt;
        int b_cold, b_cool, b_warm, b_hot, left_b, right_b;
        logic [CurrentW-1:0] zone_i, left_i, right_i, tgt, red, full;
        bit has_left, has_right;
        d = '0;
        left_b = 0;
        right_b = 0;
        left_i = '0;
        right_i = '0;
        has_left = 1'b0;
        has_right = 1'b0;
        if (!r.power_ok) begin
            tick_cnt = 0;
            first_pending = 1'b1;
            return d;
        end
        if (!r.reinit) begin
            if (tick_cnt < 255) tick_cnt++;
            if (tick_cnt < int'(cfg_shadow.sample_interval)) return d;
            tick_cnt = 0;
        end else begin
            tick_cnt = 0;
            first_pending = 1'b1;
        end

        // Pick the sensor, then the zone
        tbat   = $signed(r.battery_temp_c);
        tchip  = $signed(r.chip_temp_c);
        t      = (degree_gap(tchip, tbat) > 10) ? tchip : tbat;
        b_cold = $signed(cfg_shadow.bound_cold);
        b_cool = $signed(cfg_shadow.bound_cool);
        b_warm = $signed(cfg_shadow.bound_warm);
        b_hot  = $signed(cfg_shadow.bound_hot);
        dlt    = int'(cfg_shadow.hysteresis_delta);
        red    = cfg_shadow.reduced_current_ma;
        full   = cfg_shadow.full_current_ma;
        if (t <= b_cold) begin
            zone_i = '0;
            has_right = 1'b1; right_i = red; right_b = b_cold;
        end else if (t <= b_cool) begin
            zone_i = red;
            has_left = 1'b1; left_i = '0; left_b = b_cold;
            has_right = 1'b1; right_i = full; right_b = b_cool;
        end else if (t < b_warm) begin
            zone_i = full;
            has_left = 1'b1; left_i = red; left_b = b_cool;
            has_right = 1'b1; right_i = red; right_b = b_warm;
        end else if (t < b_hot) begin
            zone_i = red;
            has_left = 1'b1; left_i = full; left_b = b_warm;
            has_right = 1'b1; right_i = '0; right_b = b_hot;
        end else begin
            zone_i = '0;
            has_left = 1'b1; left_i = red; left_b = b_hot;
        end

        // Hold a neighbor current near a shared bound; hotter side last
        tgt = zone_i;
        if (!first_pending) begin
            if (has_left && r.current_setting_ma == left_i && degree_gap(t, left_b) <= dlt)
                tgt = left_i;
            if (has_right && r.current_setting_ma == right_i && degree_gap(t, right_b) <= dlt)
                tgt = right_i;
        end
        first_pending = 1'b0;

        d.sampled           = 1'b1;
        d.write_current     = (r.current_setting_ma != tgt);
        d.target_current_ma = tgt;
        if (tgt == '0 && r.charge_enabled) begin
            d.write_enable = 1'b1;
            d.enable_value = 1'b0;
        end else if (tgt != '0 && !r.charge_enabled) begin
            d.write_enable = 1'b1;
            d.enable_value = 1'b1;
        end
        return d;
    endfunction

    // Track config writes, check results, queue predictions
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_shadow    = '{SampleIntervalRst, HysteresisDeltaRst, BoundColdRst,
                              BoundCoolRst, BoundWarmRst, BoundHotRst,
                              ReducedCurrentRst, FullCurrentRst};
            tick_cnt      = 0;
            first_pending = 1'b1;
            req_taken    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SAMPLE_INTERVAL:  cfg_shadow.sample_interval    = cfg_wdata[IntervalW-1:0];
                    CFG_HYSTERESIS_DELTA: cfg_shadow.hysteresis_delta   = cfg_wdata[DeltaW-1:0];
                    CFG_BOUND_COLD:       cfg_shadow.bound_cold         = cfg_wdata[TempW-1:0];
                    CFG_BOUND_COOL:       cfg_shadow.bound_cool         = cfg_wdata[TempW-1:0];
                    CFG_BOUND_WARM:       cfg_shadow.bound_warm         = cfg_wdata[TempW-1:0];
                    CFG_BOUND_HOT:        cfg_shadow.bound_hot          = cfg_wdata[TempW-1:0];
                    CFG_REDUCED_CURRENT:  cfg_shadow.reduced_current_ma = cfg_wdata;
                    CFG_FULL_CURRENT:     cfg_shadow.full_current_ma    = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = '{m_sampled, m_write_current, m_target_current_ma,
                        m_write_enable, m_enable_value};
                if (pending_decisions.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: sampled=%0d wc=%0d target=%0d we=%0d ev=%0d",
                                 got.sampled, got.write_current, got.target_current_ma,
                                 got.write_enable, got.enable_value);
                end else begin
                    want = pending_decisions.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"mismatch: expected sampled=%0d wc=%0d target=%0d we=%0d ",
                                      "ev=%0d, got sampled=%0d wc=%0d target=%0d we=%0d ev=%0d"},
                                     want.sampled, want.write_current, want.target_current_ma,
                                     want.write_enable, want.enable_value,
                                     got.sampled, got.write_current, got.target_current_ma,
                                     got.write_enable, got.enable_value);
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = policy_decision('{s_power_ok, s_reinit, s_battery_temp_c,
                                         s_chip_temp_c, s_current_setting_ma,
                                         s_charge_enabled});
                if (known_valid) want = known_result;
                pending_decisions.push_back(want);
            end
            req_taken <= s_valid && s_ready;
        end
    end

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                m_ready = 1'b0;
                rx_hold--;
            end else if (aresetn && !quiet && $urandom_range(0, 6) == 0) begin
                m_ready = 1'b0;
                rx_hold = $urandom_range(0, 9);
            end else begin
                m_ready = aresetn;
            end
        end
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic signed [TempW-1:0] clamp_temp(int v);
        if (v > 127) return 8'sd127;
        if (v < -128) return -8'sd128;
        return v[TempW-1:0];
    endfunction

    function automatic logic [CurrentW-1:0] pick_current();
        case ($urandom_range(0, 5))
            0: return 13'd0;
            1: return 13'd400;
            2: return 13'd1500;
            3: return 13'd6000;
            4: return CurrentW'($urandom_range(0, 6000));
            default: return CurrentW'($urandom_range(0, 8191));
        endcase
    endfunction

    // Build one tick, mostly powered and near a zone bound
    function automatic tick_req_t random_tick(tccp_cfg_t c);
        tick_req_t r;
        int base, span;
        span = int'(c.hysteresis_delta) + 2;
        r.power_ok  = ($urandom_range(0, 24) != 0);
        r.reinit    = ($urandom_range(0, 15) == 0);
        case ($urandom_range(0, 5))
            0: base = $signed(c.bound_cold);
            1: base = $signed(c.bound_cool);
            2: base = $signed(c.bound_warm);
            3: base = $signed(c.bound_hot);
            default: base = int'($urandom_range(0, 255)) - 128;
        endcase
        r.battery_temp_c = clamp_temp(base + int'($urandom_range(0, 2 * span)) - span);
        if ($urandom_range(0, 3) != 0)
            r.chip_temp_c = clamp_temp($signed(r.battery_temp_c)
                                       + int'($urandom_range(0, 24)) - 12);
        else
            r.chip_temp_c = TempW'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0, 1, 2: r.current_setting_ma = c.reduced_current_ma;
            3, 4, 5: r.current_setting_ma = c.full_current_ma;
            6, 7:    r.current_setting_ma = '0;
            8:       r.current_setting_ma = CurrentW'($urandom_range(0, 6000));
            default: r.current_setting_ma = CurrentW'($urandom_range(0, 8191));
        endcase
        r.charge_enabled = 1'($urandom_range(0, 1));
        // Occasional raw noise over every bit
        if ($urandom_range(0, 19) == 0) r = tick_req_t'($urandom);
        return r;
    endfunction

    function automatic tccp_cfg_t phase_config(int ph);
        tccp_cfg_t c;
        int b0;
        case (ph)
            0: c = '{8'd255, 4'd0, 8'h80, 8'hC0, 8'd64, 8'd127, 13'd0, 13'd8191};
            1: c = '{8'd0, 4'd15, 8'hCE, 8'd30, 8'd10, 8'd40, 13'd6000, 13'd6000};
            2: c = '{8'd1, 4'd3, 8'hFE, 8'd0, 8'd2, 8'd4, 13'd400, 13'd1500};
            3: c = '{SampleIntervalRst, HysteresisDeltaRst, BoundColdRst, BoundCoolRst,
                     BoundWarmRst, BoundHotRst, ReducedCurrentRst, FullCurrentRst};
            default: begin
                case ($urandom_range(0, 9))
                    0:       c.sample_interval = IntervalW'($urandom_range(0, 255));
                    1, 2:    c.sample_interval = IntervalW'($urandom_range(7, 40));
                    default: c.sample_interval = IntervalW'($urandom_range(0, 6));
                endcase
                c.hysteresis_delta = DeltaW'($urandom_range(0, 15));
                if ($urandom_range(0, 3) != 0) begin
                    // Ordered bounds with random spacing
                    b0 = int'($urandom_range(0, 140)) - 100;
                    c.bound_cold = clamp_temp(b0);
                    b0 = b0 + int'($urandom_range(0, 30));
                    c.bound_cool = clamp_temp(b0);
                    b0 = b0 + int'($urandom_range(0, 40));
                    c.bound_warm = clamp_temp(b0);
                    b0 = b0 + int'($urandom_range(0, 30));
                    c.bound_hot  = clamp_temp(b0);
                end else begin
                    c.bound_cold = TempW'($urandom_range(0, 255));
                    c.bound_cool = TempW'($urandom_range(0, 255));
                    c.bound_warm = TempW'($urandom_range(0, 255));
                    c.bound_hot  = TempW'($urandom_range(0, 255));
                end
                c.reduced_current_ma = pick_current();
                c.full_current_ma    = pick_current();
            end
        endcase
        return c;
    endfunction

    // Write one register; bits above its width carry junk
    task automatic write_reg(input tccp_cfg_idx_t idx, input logic [CfgDataW-1:0] value,
                             input int bits);
        logic [CfgDataW-1:0] junk;
        junk      = CfgDataW'($urandom);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = (junk << bits) | value;
        @(negedge aclk);
    endtask

    task automatic apply_config(input tccp_cfg_t c);
        write_reg(CFG_SAMPLE_INTERVAL, CfgDataW'(c.sample_interval), IntervalW);
        write_reg(CFG_HYSTERESIS_DELTA, CfgDataW'(c.hysteresis_delta), DeltaW);
        write_reg(CFG_BOUND_COLD, CfgDataW'(c.bound_cold), TempW);
        write_reg(CFG_BOUND_COOL, CfgDataW'(c.bound_cool), TempW);
        write_reg(CFG_BOUND_WARM, CfgDataW'(c.bound_warm), TempW);
        write_reg(CFG_BOUND_HOT, CfgDataW'(c.bound_hot), TempW);
        write_reg(CFG_REDUCED_CURRENT, c.reduced_current_ma, CurrentW);
        write_reg(CFG_FULL_CURRENT, c.full_current_ma, CurrentW);
        cfg_wr_en = 1'b0;
    endtask

    // Offer one request and hold it until taken
    task automatic send_tick(input tick_req_t r, input bit known, input charge_decision_t res);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid              = 1'b1;
        s_power_ok           = r.power_ok;
        s_reinit             = r.reinit;
        s_battery_temp_c     = r.battery_temp_c;
        s_chip_temp_c        = r.chip_temp_c;
        s_current_setting_ma = r.current_setting_ma;
        s_charge_enabled     = r.charge_enabled;
        known_valid          = known;
        known_result         = res;
        do @(negedge aclk); while (!req_taken);
    endtask

    // Drop valid and wait for every queued result
    task automatic drain_results();
        s_valid = 1'b0;
        while (pending_decisions.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int ph;
        int waited;
        tccp_cfg_t phase_cfg;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_rows[k])
            send_tick(directed_rows[k].req, directed_rows[k].known, directed_rows[k].result);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            phase_cfg = phase_config(ph);
            apply_config(phase_cfg);
            quiet = (ph == NUM_PHASES - 1);
            if (ph == 3) hold_off_request = 1'b1;
            repeat (TICKS_PER_PHASE) send_tick(random_tick(phase_cfg), 1'b0, NO_DECISION);
        end

        // Let the pipeline empty, then keep watching for stray results
        s_valid = 1'b0;
        waited = 0;
        while (pending_decisions.size() != 0 && waited < 2000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (4) @(negedge aclk);
        if (pending_decisions.size() != 0) begin
            error_count += pending_decisions.size();
            $display("%0d expected results never arrived", pending_decisions.size());
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/tccp_pkg.sv
rtl/tccp_cfg_regs.sv
rtl/tccp_decide.sv
rtl/thermal_charge_current_policy_unit.sv
sim/testbench.sv
